[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/nlq_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest level quantizer package
// Field widths, mode codes and the item record carried down the pipeline.
// ----------------------------------------------------------------------------
package nlq_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;
  localparam int CODE_W = 8;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUANT = 1'b1
  } nlq_mode_t;

  typedef struct packed {
    logic                     vld;
    logic                     quant;
    logic                     wen;
    logic [IDX_W-1:0]         widx;
    logic signed [DATA_W-1:0] value;
  } nlq_item_t;

endpackage

[hw/rtl/nlq_if.sv]
// ----------------------------------------------------------------------------
// Nearest level quantizer channels
// Valid/ready interfaces for the input beat and the result beat.
// ----------------------------------------------------------------------------
interface nlq_in_if import nlq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] level_or_sample;

  modport source(output valid, mode, entry_index, level_or_sample, input ready);
  modport sink(input valid, mode, entry_index, level_or_sample, output ready);
endinterface

interface nlq_out_if import nlq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_index;

  modport source(output valid, code_index, input ready);
  modport sink(input valid, code_index, output ready);
endinterface

[hw/rtl/nlq_step.sv]
// ----------------------------------------------------------------------------
// Nearest level quantizer search step
// One halving step: probe a private codebook copy, then narrow the range.
// ----------------------------------------------------------------------------
module nlq_step import nlq_pkg::*; #(
  parameter int LEVELS = 256,
  localparam int LW    = $clog2(LEVELS + 1),
  localparam int DEPTH = (LEVELS < 256) ? LEVELS : 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  nlq_item_t       item_i,
  input  logic [LW-1:0]   lo_i,
  input  logic [LW-1:0]   cnt_i,
  output nlq_item_t       item_o,
  output logic [LW-1:0]   lo_o,
  output logic [LW-1:0]   cnt_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_r;
  nlq_item_t                item_r;
  logic [LW-1:0]            lo_r;
  logic [LW-1:0]            cnt_r;
  logic [LW-1:0]            probe;
  logic [LW-1:0]            half_r;
  logic [LW-1:0]            probe_r;
  logic                     go;

  assign probe = lo_i + (cnt_i >> 1);

  always_ff @(posedge clk) begin
    if (adv && item_i.vld && item_i.wen) begin
      mem[item_i.widx[AW-1:0]] <= item_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[probe[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (adv) begin
      item_r <= item_i;
      lo_r   <= lo_i;
      cnt_r  <= cnt_i;
    end
  end

  // resolve the probe read from the registered read data and item fields
  assign half_r  = cnt_r >> 1;
  assign probe_r = lo_r + half_r;
  assign go      = (cnt_r != '0) && (rd_r < item_r.value);
  assign lo_o    = go ? probe_r + LW'(1) : lo_r;
  assign cnt_o   = go ? cnt_r - half_r - LW'(1) : half_r;
  assign item_o  = item_r;

endmodule

[hw/rtl/nlq_pick.sv]
// ----------------------------------------------------------------------------
// Nearest level quantizer neighbor pick
// Read the levels around the search result, compare gaps, register the code.
// ----------------------------------------------------------------------------
module nlq_pick import nlq_pkg::*; #(
  parameter int LEVELS = 256,
  localparam int LW    = $clog2(LEVELS + 1),
  localparam int DEPTH = (LEVELS < 256) ? LEVELS : 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  nlq_item_t         item_i,
  input  logic [LW-1:0]     lo_i,
  output logic              out_vld,
  output logic [CODE_W-1:0] out_code
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [LW-1:0]            im1;

  // stage 0: neighbor reads
  nlq_item_t                p0_item_r;
  logic [LW-1:0]            p0_i_r;
  logic [LW-1:0]            p0_im1_r;
  logic                     p0_end_r;
  logic                     p0_zero_r;
  logic signed [DATA_W-1:0] p0_lv_lo_r;
  logic signed [DATA_W-1:0] p0_lv_hi_r;
  // stage 1: signed gaps
  logic                     p1_vld_r;
  logic [LW-1:0]            p1_i_r;
  logic [LW-1:0]            p1_im1_r;
  logic                     p1_end_r;
  logic                     p1_zero_r;
  logic signed [DATA_W:0]   p1_below_r;
  logic signed [DATA_W:0]   p1_above_r;
  // stage 2: gap magnitudes
  logic                     p2_vld_r;
  logic [LW-1:0]            p2_i_r;
  logic [LW-1:0]            p2_im1_r;
  logic                     p2_end_r;
  logic                     p2_zero_r;
  logic [DATA_W:0]          p2_below_r;
  logic [DATA_W:0]          p2_above_r;
  // stage 3: result
  logic                     p3_vld_r;
  logic [CODE_W-1:0]        p3_code_r;
  logic [CODE_W-1:0]        code_nxt;
  logic signed [DATA_W:0]   below_nxt;
  logic signed [DATA_W:0]   above_nxt;

  assign im1 = lo_i - LW'(1);

  always_ff @(posedge clk) begin
    if (adv && item_i.vld && item_i.wen) begin
      mem[item_i.widx[AW-1:0]] <= item_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_lv_lo_r <= mem[im1[AW-1:0]];
      p0_lv_hi_r <= mem[lo_i[AW-1:0]];
    end
  end

  assign below_nxt = (DATA_W + 1)'(p0_item_r.value) - (DATA_W + 1)'(p0_lv_lo_r);
  assign above_nxt = (DATA_W + 1)'(p0_lv_hi_r) - (DATA_W + 1)'(p0_item_r.value);

  always_comb begin
    if (p2_end_r) begin
      code_nxt = CODE_W'(LEVELS - 1);
    end else if (p2_zero_r) begin
      code_nxt = '0;
    end else if (p2_below_r <= p2_above_r) begin
      code_nxt = CODE_W'(p2_im1_r);
    end else begin
      code_nxt = CODE_W'(p2_i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_item_r.vld <= 1'b0;
      p1_vld_r      <= 1'b0;
      p2_vld_r      <= 1'b0;
      p3_vld_r      <= 1'b0;
    end else if (adv) begin
      p0_item_r  <= item_i;
      p0_i_r     <= lo_i;
      p0_im1_r   <= im1;
      p0_end_r   <= (lo_i >= LW'(LEVELS));
      p0_zero_r  <= (lo_i == '0);

      p1_vld_r   <= p0_item_r.vld && p0_item_r.quant;
      p1_i_r     <= p0_i_r;
      p1_im1_r   <= p0_im1_r;
      p1_end_r   <= p0_end_r;
      p1_zero_r  <= p0_zero_r;
      p1_below_r <= below_nxt;
      p1_above_r <= above_nxt;

      p2_vld_r   <= p1_vld_r;
      p2_i_r     <= p1_i_r;
      p2_im1_r   <= p1_im1_r;
      p2_end_r   <= p1_end_r;
      p2_zero_r  <= p1_zero_r;
      p2_below_r <= p1_below_r[DATA_W] ? -p1_below_r : p1_below_r;
      p2_above_r <= p1_above_r[DATA_W] ? -p1_above_r : p1_above_r;

      p3_vld_r   <= p2_vld_r;
      p3_code_r  <= code_nxt;
    end
  end

  assign out_vld  = p3_vld_r;
  assign out_code = p3_code_r;

endmodule

[hw/rtl/nearest_level_quantizer_core.sv]
// Throughput: one beat per cycle while no result beat is held at the output;
// each halving step owns a codebook copy and one read port.
// A held result beat freezes the whole pipeline until it is taken; load beats give no result.
// Reset clears the valid bits only; codebook copies hold garbage until loaded.
// ----------------------------------------------------------------------------
// Nearest level quantizer core
// Pipelined binary search over a loaded codebook, then nearest-neighbor pick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_level_quantizer_core import nlq_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  nlq_in_if.sink    in_bus,
  nlq_out_if.source out_bus
);

  localparam int LW     = $clog2(LEVELS + 1);
  localparam int NSTEPS = LW;

  nlq_item_t         chain_item [NSTEPS + 1];
  logic [LW-1:0]     chain_lo   [NSTEPS + 1];
  logic [LW-1:0]     chain_cnt  [NSTEPS + 1];
  logic              adv;
  logic              out_vld;
  logic [CODE_W-1:0] out_code;

  assign adv          = !out_vld || out_bus.ready;
  assign in_bus.ready = adv;

  always_comb begin
    chain_item[0].vld   = in_bus.valid;
    chain_item[0].quant = (in_bus.mode == MODE_QUANT);
    chain_item[0].wen   = (in_bus.mode == MODE_LOAD) &&
                          (32'(in_bus.entry_index) < 32'(LEVELS));
    chain_item[0].widx  = in_bus.entry_index;
    chain_item[0].value = in_bus.level_or_sample;
    chain_lo[0]         = '0;
    chain_cnt[0]        = LW'(LEVELS);
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    nlq_step #(.LEVELS(LEVELS)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (chain_item[k]),
      .lo_i   (chain_lo[k]),
      .cnt_i  (chain_cnt[k]),
      .item_o (chain_item[k+1]),
      .lo_o   (chain_lo[k+1]),
      .cnt_o  (chain_cnt[k+1])
    );
  end

  nlq_pick #(.LEVELS(LEVELS)) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item_i   (chain_item[NSTEPS]),
    .lo_i     (chain_lo[NSTEPS]),
    .out_vld  (out_vld),
    .out_code (out_code)
  );

  assign out_bus.valid      = out_vld;
  assign out_bus.code_index = out_code;

  `ASSERT_ALW(a_stall_only_on_held_beat, clk, !in_bus.ready |-> out_bus.valid, "stall without a held result beat")
  `ASSERT_RST(a_code_in_range, clk, rst_n, out_bus.valid |-> (32'(out_bus.code_index) <= 32'(LEVELS - 1)) || (LEVELS > 256), "code beyond last level")
  `ASSERT_RST(a_search_in_range, clk, rst_n, chain_item[NSTEPS].vld && chain_item[NSTEPS].quant |-> (32'(chain_lo[NSTEPS]) <= 32'(LEVELS)), "search ran past the codebook")

endmodule

[tb/nearest_level_quantizer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest level quantizer core testbench
// Loads full codebooks of several shapes (unit steps, sparse ascending runs
// with runs of duplicates, scrambled) and then quantizes samples placed
// on levels, next to them, on midpoints and at the range ends. Random gaps
// appear on both channels. Each result beat is compared with a typed code
// of a directed row or with a local binary search model of the codebook.
// ----------------------------------------------------------------------------
module nearest_level_quantizer_core_tb;
  import nlq_pkg::*;

  localparam int LEVELS          = 256;
  localparam int PIPE_LATENCY    = $clog2(LEVELS + 1) + 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 2;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int MAX_PRINTED     = 200;

  localparam logic signed [DATA_W-1:0] LEVEL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    BOOK_UNIT,
    BOOK_DENSE,
    BOOK_SPARSE,
    BOOK_SCRAMBLED,
    BOOK_FLAT
  } book_style_t;

  typedef struct packed {
    nlq_mode_t         mode;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic [CODE_W-1:0] code;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{MODE_QUANT, 8'h00, 32'h8000_0000, 1'b1, 8'd0},
    '{MODE_QUANT, 8'hFF, 32'h7FFF_FFFF, 1'b1, 8'd255},
    '{MODE_QUANT, 8'hA5, 32'h0000_0000, 1'b1, 8'd128},
    '{MODE_QUANT, 8'h5A, 32'h8500_0000, 1'b1, 8'd5},
    '{MODE_QUANT, 8'h00, 32'h0080_0000, 1'b1, 8'd128},
    '{MODE_QUANT, 8'h00, 32'h0080_0001, 1'b1, 8'd129},
    '{MODE_QUANT, 8'h00, 32'h007F_FFFF, 1'b1, 8'd128},
    '{MODE_QUANT, 8'h00, 32'h7E80_0000, 1'b1, 8'd254},
    '{MODE_QUANT, 8'h00, 32'h7F00_0000, 1'b1, 8'd255},
    '{MODE_QUANT, 8'h00, 32'h8080_0000, 1'b1, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h8080_0001, 1'b1, 8'd1},
    '{MODE_QUANT, 8'h00, 32'h8000_0001, 1'b1, 8'd0},
    '{MODE_LOAD,  8'hFF, 32'h7FFF_FFFF, 1'b0, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h7FFF_FFFF, 1'b1, 8'd255},
    '{MODE_QUANT, 8'h00, 32'h7F80_0000, 1'b0, 8'd0},
    '{MODE_LOAD,  8'h01, 32'h7FFF_FFFF, 1'b0, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h0000_0000, 1'b0, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h8040_0000, 1'b0, 8'd0},
    '{MODE_LOAD,  8'h01, 32'h8100_0000, 1'b0, 8'd0},
    '{MODE_LOAD,  8'h81, 32'h0000_0000, 1'b0, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h0000_0000, 1'b0, 8'd0},
    '{MODE_QUANT, 8'h00, 32'h0080_0000, 1'b0, 8'd0},
    '{MODE_QUANT, 8'hFF, 32'h1234_5678, 1'b0, 8'd0}
  };

  localparam book_style_t PHASE_BOOKS [RANDOM_PHASES] = '{
    BOOK_SPARSE, BOOK_SCRAMBLED
  };

  logic clk = 1'b0;
  logic rst_n;

  nlq_in_if  in_bus ();
  nlq_out_if out_bus ();

  nearest_level_quantizer_core #(
    .LEVELS (LEVELS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  logic signed [DATA_W-1:0] level_table [LEVELS];
  logic [CODE_W-1:0]        code_queue [$];
  int                       error_count = 0;
  int                       cycle_count = 0;
  bit                       src_idle  = 1'b1;
  bit                       sink_idle = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CODE_W-1:0] nearest_code(input logic signed [DATA_W-1:0] sample);
    int unsigned lo;
    int unsigned count;
    int unsigned half;
    int unsigned probe;
    longint      below_gap;
    longint      above_gap;
    lo    = 0;
    count = LEVELS;
    while (count > 0) begin
      half  = count / 2;
      probe = lo + half;
      if (probe < LEVELS && level_table[probe] < sample) begin
        lo    = probe + 1;
        count = count - (half + 1);
      end else begin
        count = half;
      end
    end
    if (lo >= LEVELS) return CODE_W'(LEVELS - 1);
    if (lo == 0) return '0;
    below_gap = longint'(sample) - longint'(level_table[lo-1]);
    above_gap = longint'(level_table[lo]) - longint'(sample);
    if (below_gap < 0) below_gap = -below_gap;
    if (above_gap < 0) above_gap = -above_gap;
    return (below_gap <= above_gap) ? CODE_W'(lo - 1) : CODE_W'(lo);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_level(input longint v);
    if (v > longint'(LEVEL_MAX)) return LEVEL_MAX;
    if (v < longint'(LEVEL_MIN)) return LEVEL_MIN;
    return DATA_W'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_between(input longint lo, input longint hi);
    if (hi <= lo) return clamp_level(lo);
    return clamp_level(lo + longint'($urandom_range(32'(hi - lo), 0)));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    int     j;
    longint here_level;
    longint next_level;
    j          = $urandom_range(LEVELS - 2, 0);
    here_level = longint'(level_table[j]);
    next_level = longint'(level_table[j+1]);
    case ($urandom_range(5, 0))
      0: return level_table[j];
      1: return clamp_level(here_level + longint'($urandom_range(8, 0)) - 4);
      2: return clamp_level(((here_level + next_level) >>> 1) + longint'($urandom_range(1, 0)));
      3: return ($urandom_range(1, 0) != 0) ? LEVEL_MAX : LEVEL_MIN;
      4: begin
        if (here_level <= next_level) return random_between(here_level, next_level);
        return random_between(next_level, here_level);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_beat(input nlq_mode_t mode, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] value, input bit typed,
                           input logic [CODE_W-1:0] typed_code);
    int gap;
    gap = src_idle ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.mode            <= mode;
    in_bus.entry_index     <= idx;
    in_bus.level_or_sample <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (mode == MODE_LOAD) begin
      level_table[idx] = value;
    end else begin
      code_queue.push_back(typed ? typed_code : nearest_code(value));
    end
    @(negedge clk);
  endtask

  task automatic load_codebook(input book_style_t style);
    longint                   acc;
    logic signed [DATA_W-1:0] flat_value;
    logic signed [DATA_W-1:0] value;
    if (style == BOOK_SPARSE) begin
      acc = longint'(LEVEL_MIN);
    end else begin
      acc = longint'(LEVEL_MIN) + longint'($urandom_range(32'hEFFF_FFFF, 0));
    end
    flat_value = $urandom;
    for (int k = 0; k < LEVELS; k++) begin
      case (style)
        BOOK_UNIT: value = clamp_level(longint'(k - LEVELS / 2) <<< 24);
        BOOK_DENSE: begin
          value = clamp_level(acc);
          acc   = acc + longint'($urandom_range(1 << 20, 0));
        end
        BOOK_SPARSE: begin
          value = clamp_level(acc);
          if ($urandom_range(3, 0) != 0) acc = acc + longint'($urandom_range(1 << 25, 0));
        end
        BOOK_SCRAMBLED: value = $urandom;
        default: value = flat_value;
      endcase
      send_beat(MODE_LOAD, IDX_W'(k), value, 1'b0, '0);
    end
  endtask

  task automatic update_level();
    int                       idx;
    longint                   lo;
    longint                   hi;
    logic signed [DATA_W-1:0] value;
    idx = $urandom_range(LEVELS - 1, 0);
    lo  = (idx == 0) ? longint'(LEVEL_MIN) : longint'(level_table[idx-1]);
    hi  = (idx == LEVELS - 1) ? longint'(LEVEL_MAX) : longint'(level_table[idx+1]);
    if ($urandom_range(9, 0) < 7) begin
      value = random_between(lo, hi);
    end else begin
      value = $urandom;
    end
    send_beat(MODE_LOAD, IDX_W'(idx), value, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int                gap;
    logic [CODE_W-1:0] expected;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(7, 0) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      if (code_queue.size() == 0) begin
        report_error($sformatf("result beat with no pending sample, code_index %0d",
                               out_bus.code_index));
      end else begin
        expected = code_queue.pop_front();
        if (out_bus.code_index !== expected) begin
          report_error($sformatf("code_index %0d, expected %0d", out_bus.code_index, expected));
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    stim_row_t row;
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.mode            = MODE_LOAD;
    in_bus.entry_index     = '0;
    in_bus.level_or_sample = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_codebook(BOOK_UNIT);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED_TABLE[r];
      send_beat(row.mode, row.idx, row.value, row.typed, row.code);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_codebook(PHASE_BOOKS[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 64 == 0) begin
          src_idle  = ($urandom_range(3, 0) != 0);
          sink_idle = ($urandom_range(3, 0) != 0);
        end
        if ($urandom_range(9, 0) == 0) begin
          update_level();
        end else begin
          send_beat(MODE_QUANT, IDX_W'($urandom), pick_sample(), 1'b0, '0);
        end
      end
    end
    in_bus.valid <= 1'b0;

    while (code_queue.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/nlq_pkg.sv
hw/rtl/nlq_if.sv
hw/rtl/nlq_step.sv
hw/rtl/nlq_pick.sv
hw/rtl/nearest_level_quantizer_core.sv
tb/nearest_level_quantizer_core_tb.sv
